// ===== hw/rtl/mbus_long_frame_meter_parser_unit_assert.svh =====
// Assertion macros shared by the parser modules.
// Each expects aclk and aresetn in scope.
`ifndef MBUS_LONG_FRAME_METER_PARSER_UNIT_ASSERT_SVH
`define MBUS_LONG_FRAME_METER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication
`define MLFMP_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication
`define MLFMP_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/mlfmp_pkg.sv =====
`default_nettype none

package mlfmp_pkg;

    // Frame geometry
    localparam int MAX_FRAME_BYTES_DEF = 512;
    localparam int ITEM_COUNT          = 14;
    localparam int MIN_FRAME_BYTES     = 112;
    localparam int SUM_START           = 4;
    localparam int MIDDLE_POS          = 3;
    localparam int LENGTH_POS          = 1;
    localparam int CMP_W               = 10;
    localparam int QUEUE_DEPTH         = 2;

    // First byte and size of each captured item
    localparam logic [7:0] ITEM_BASE [ITEM_COUNT] = '{
        8'd13, 8'd16, 8'd22, 8'd31, 8'd38, 8'd45, 8'd51,
        8'd72, 8'd84, 8'd88, 8'd92, 8'd96, 8'd102, 8'd108
    };
    localparam logic [2:0] ITEM_SIZE [ITEM_COUNT] = '{
        3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4
    };

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_MARKER = 2'd1,
        ST_BAD_SUM    = 2'd2,
        ST_SHORT      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_START_MARKER  = 2'd0,
        CFG_MIDDLE_MARKER = 2'd1,
        CFG_STOP_MARKER   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
        logic [2:0] channel;
    } in_t;

    typedef struct packed {
        status_t     frame_status;
        logic [3:0]  item_index;
        logic [31:0] item_value;
        logic [2:0]  result_channel;
        logic        last_item;
    } out_t;

    // One finished frame handed from front to back
    typedef struct packed {
        status_t                         status;
        logic [2:0]                      channel;
        logic [ITEM_COUNT-1:0][31:0]     items;
    } frame_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mlfmp_front.sv =====
`default_nettype none

module mlfmp_front
    import mlfmp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_t        s_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       q_full,
    output logic            push,
    output frame_rec_t      push_rec
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES);

    logic [7:0] start_marker_reg, middle_marker_reg, stop_marker_reg;

    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    sum_reg, sum_next;
    logic          marker_reg, marker_next;
    logic [7:0]    prev_reg, prev_next;
    logic [ITEM_COUNT-1:0][31:0] items_reg, items_next;

    logic [7:0]       sum_now;
    logic             marker_now;
    logic [ITEM_COUNT-1:0][31:0] items_now;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] rel;
    logic             in_range;
    logic             accept;
    status_t          status;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;

    // Marker configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg  <= 8'h68;
            middle_marker_reg <= 8'h68;
            stop_marker_reg   <= 8'h16;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_START_MARKER:  start_marker_reg  <= cfg_data;
                CFG_MIDDLE_MARKER: middle_marker_reg <= cfg_data;
                CFG_STOP_MARKER:   stop_marker_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-byte update: markers, length, checksum window, item capture
    always_comb begin
        pos_ext    = CMP_W'(pos_reg);
        in_range   = (pos_reg < POS_MAX);
        marker_now = marker_reg;
        len_next   = len_reg;
        sum_now    = sum_reg;
        items_now  = items_reg;
        rel        = '0;
        if (in_range) begin
            if (pos_ext == '0 && s_data.rx_byte != start_marker_reg) begin
                marker_now = 1'b0;
            end
            if (pos_ext == CMP_W'(MIDDLE_POS) && s_data.rx_byte != middle_marker_reg) begin
                marker_now = 1'b0;
            end
            if (pos_ext == CMP_W'(LENGTH_POS)) begin
                len_next = s_data.rx_byte;
            end
            if (pos_ext >= CMP_W'(SUM_START)
                    && pos_ext < CMP_W'(SUM_START) + CMP_W'(len_reg)) begin
                sum_now = sum_reg + s_data.rx_byte;
            end
            for (int k = 0; k < ITEM_COUNT; k++) begin
                rel = pos_ext - CMP_W'(ITEM_BASE[k]);
                if (pos_ext >= CMP_W'(ITEM_BASE[k])
                        && pos_ext < CMP_W'(ITEM_BASE[k]) + CMP_W'(ITEM_SIZE[k])) begin
                    items_now[k][rel[1:0]*8 +: 8] = s_data.rx_byte;
                end
            end
        end
    end

    // Frame check on the last byte; markers win over checksum over length
    always_comb begin
        if (!marker_now || pos_ext < CMP_W'(MIDDLE_POS)
                || s_data.rx_byte != stop_marker_reg) begin
            status = ST_BAD_MARKER;
        end else if (sum_now != prev_reg) begin
            status = ST_BAD_SUM;
        end else if (pos_ext < CMP_W'(MIN_FRAME_BYTES - 1)) begin
            status = ST_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    assign push             = accept && s_data.frame_end;
    assign push_rec.status  = status;
    assign push_rec.channel = s_data.channel;
    assign push_rec.items   = items_now;

    // Next state: advance on a byte, clear after the last one
    always_comb begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        marker_next = marker_reg;
        prev_next   = prev_reg;
        items_next  = items_reg;
        if (accept) begin
            if (s_data.frame_end) begin
                pos_next    = '0;
                sum_next    = '0;
                marker_next = 1'b1;
                prev_next   = '0;
                items_next  = '0;
            end else begin
                sum_next    = sum_now;
                marker_next = marker_now;
                prev_next   = s_data.rx_byte;
                items_next  = items_now;
                if (in_range) begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            len_reg    <= '0;
            sum_reg    <= '0;
            marker_reg <= 1'b1;
            prev_reg   <= '0;
            items_reg  <= '0;
        end else begin
            pos_reg    <= pos_next;
            len_reg    <= (accept && s_data.frame_end) ? 8'd0 :
                          (accept ? len_next : len_reg);
            sum_reg    <= sum_next;
            marker_reg <= marker_next;
            prev_reg   <= prev_next;
            items_reg  <= items_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mlfmp_queue.sv =====
`default_nettype none

`include "mbus_long_frame_meter_parser_unit_assert.svh"

module mlfmp_queue
    import mlfmp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire frame_rec_t push_rec,
    output logic            full,
    input  wire logic       pop,
    output logic            q_valid,
    output frame_rec_t      head
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    frame_rec_t entry_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg;

    assign full    = (count_reg == QCW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `MLFMP_ASSERT_IMPLY(a_no_push_full, full, !push, "push into full queue")
    `MLFMP_ASSERT_IMPLY(a_no_pop_empty, !q_valid, !pop, "pop from empty queue")
    `MLFMP_ASSERT_NEXT(a_push_fills, push && !pop, q_valid, "queue empty after push")

endmodule

`default_nettype wire

// ===== hw/rtl/mlfmp_back.sv =====
`default_nettype none

`include "mbus_long_frame_meter_parser_unit_assert.svh"

module mlfmp_back
    import mlfmp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    input  wire frame_rec_t head,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_t            m_data
);

    localparam logic [3:0] LAST_IDX = 4'(ITEM_COUNT - 1);

    logic [3:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;
    logic       load;

    assign load    = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Walk the head frame: one error result or one result per item
    always_comb begin
        idx_next     = idx_reg;
        pop          = 1'b0;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next                = 1'b1;
            m_data_next.frame_status    = head.status;
            m_data_next.result_channel  = head.channel;
            if (head.status != ST_OK) begin
                m_data_next.item_index = '0;
                m_data_next.item_value = '0;
                m_data_next.last_item  = 1'b1;
                pop                    = 1'b1;
                idx_next               = '0;
            end else begin
                m_data_next.item_index = idx_reg;
                m_data_next.item_value = head.items[idx_reg];
                m_data_next.last_item  = (idx_reg == LAST_IDX);
                if (idx_reg == LAST_IDX) begin
                    pop      = 1'b1;
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    `MLFMP_ASSERT_IMPLY(a_idx_range, 1'b1, idx_reg <= LAST_IDX, "item index out of range")
    `MLFMP_ASSERT_IMPLY(a_pop_on_load, pop, load, "pop without output load")
    `MLFMP_ASSERT_IMPLY(a_err_is_last, m_valid_reg && m_data_reg.frame_status != ST_OK,
        m_data_reg.last_item, "error result not marked last")

endmodule

`default_nettype wire

// ===== hw/rtl/mbus_long_frame_meter_parser_unit.sv =====
`default_nettype none

// The finished frame is written into the frame queue, then its first result is registered.
// Bytes enter one per cycle while the queue is not full; results leave one per cycle from the
// output register while m_ready is high. A good frame yields 14 results, a bad one a single
// result; a two-entry frame queue lets bytes of the next frame flow in meanwhile.
// Reset (aresetn low, synchronous) empties the queue and output and restores marker defaults.

module mbus_long_frame_meter_parser_unit
    import mlfmp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_t        s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_t            m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic       push, q_full, pop, q_valid;
    frame_rec_t push_rec, head;

    // Byte parser and frame checker
    mlfmp_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_rec  (push_rec)
    );

    // Finished-frame queue
    mlfmp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    // Result sequencer
    mlfmp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mlfmp_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned SETTLE_CYCLES    = 16;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned PHASE_FRAMES     = 1;
    localparam logic [1:0]  CFG_UNUSED_INDEX = 2'd3;

    typedef enum int unsigned {
        FAULT_NONE,
        FAULT_START,
        FAULT_MIDDLE,
        FAULT_STOP,
        FAULT_SUM,
        FAULT_TRUNC
    } fault_t;

    // Frame decoder model and queue of expected meter readings
    class meter_frame_scoreboard;
        logic [7:0]  start_mk, middle_mk, stop_mk;
        int unsigned byte_pos;
        logic [7:0]  len_byte, sum_acc, prior_byte;
        bit          markers_good;
        logic [31:0] readings [ITEM_COUNT];
        int unsigned field_first [ITEM_COUNT] =
            '{13, 16, 22, 31, 38, 45, 51, 72, 84, 88, 92, 96, 102, 108};
        int unsigned field_bytes [ITEM_COUNT] =
            '{1, 1, 4, 4, 4, 4, 4, 4, 2, 2, 2, 4, 4, 4};
        out_t        pending_readings [$];
        int unsigned errors, results_checked, frames_ok, frames_bad;

        function void clear_frame();
            byte_pos     = 0;
            len_byte     = '0;
            sum_acc      = '0;
            prior_byte   = '0;
            markers_good = 1'b1;
            foreach (readings[k]) readings[k] = '0;
        endfunction

        function void reset_all();
            start_mk  = 8'h68;
            middle_mk = 8'h68;
            stop_mk   = 8'h16;
            clear_frame();
        endfunction

        function void write_marker(logic [1:0] idx, logic [7:0] v);
            case (cfg_index_t'(idx))
                CFG_START_MARKER:  start_mk  = v;
                CFG_MIDDLE_MARKER: middle_mk = v;
                CFG_STOP_MARKER:   stop_mk   = v;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return pending_readings.size();
        endfunction

        // Accepted byte transaction: update frame state, predict on frame end
        function void note_byte(in_t t);
            int unsigned p;
            int unsigned count;
            status_t     st;
            out_t        r;
            p = byte_pos;
            if (p < MAX_FRAME_BYTES_DEF) begin
                if (p == 0 && t.rx_byte != start_mk) markers_good = 1'b0;
                if (p == LENGTH_POS) len_byte = t.rx_byte;
                if (p == MIDDLE_POS && t.rx_byte != middle_mk) markers_good = 1'b0;
                if (p >= SUM_START && p < SUM_START + len_byte) sum_acc += t.rx_byte;
                for (int k = 0; k < ITEM_COUNT; k++) begin
                    if (p >= field_first[k] && p < field_first[k] + field_bytes[k])
                        readings[k][8 * (p - field_first[k]) +: 8] = t.rx_byte;
                end
            end
            if (!t.frame_end) begin
                prior_byte = t.rx_byte;
                if (byte_pos < MAX_FRAME_BYTES_DEF) byte_pos++;
                return;
            end

            // End of frame: markers, then checksum, then length
            count = p + 1;
            if (!markers_good || count <= MIDDLE_POS || t.rx_byte != stop_mk)
                st = ST_BAD_MARKER;
            else if (sum_acc != prior_byte)
                st = ST_BAD_SUM;
            else if (count < MIN_FRAME_BYTES)
                st = ST_SHORT;
            else
                st = ST_OK;

            if (st != ST_OK) begin
                r.frame_status   = st;
                r.item_index     = '0;
                r.item_value     = '0;
                r.result_channel = t.channel;
                r.last_item      = 1'b1;
                pending_readings.push_back(r);
                frames_bad++;
            end else begin
                for (int k = 0; k < ITEM_COUNT; k++) begin
                    r.frame_status   = ST_OK;
                    r.item_index     = 4'(k);
                    r.item_value     = readings[k];
                    r.result_channel = t.channel;
                    r.last_item      = (k == ITEM_COUNT - 1);
                    pending_readings.push_back(r);
                end
                frames_ok++;
            end
            clear_frame();
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Accepted result transaction against the oldest expected reading
        function void check_reading(out_t got);
            out_t want;
            if (pending_readings.size() == 0) begin
                $error("unexpected result: status %0d index %0d value 0x%0h",
                       got.frame_status, got.item_index, got.item_value);
                errors++;
                return;
            end
            want = pending_readings.pop_front();
            cmp_field("frame_status", want.frame_status, got.frame_status);
            cmp_field("item_index", want.item_index, got.item_index);
            cmp_field("item_value", want.item_value, got.item_value);
            cmp_field("result_channel", want.result_channel, got.result_channel);
            cmp_field("last_item", want.last_item, got.last_item);
            results_checked++;
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_t        s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_t       m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    meter_frame_scoreboard board;
    logic [7:0]  frame_bytes [$];
    logic [7:0]  cur_start  = 8'h68;
    logic [7:0]  cur_middle = 8'h68;
    logic [7:0]  cur_stop   = 8'h16;
    bit          idle_on    = 1'b1;
    bit          rx_hold    = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    mbus_long_frame_meter_parser_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Transaction monitor: config, input and result channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_marker(cfg_index, cfg_data);
            if (s_valid && s_ready) board.note_byte(s_data);
            if (m_valid && m_ready) board.check_reading(m_data);
        end
    end

    // Timeout
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result receiver: random stall bursts, one long hold on request
    always begin
        @(posedge aclk);
        if (rx_hold) begin
            m_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            rx_hold = 1'b0;
            m_ready <= 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input in_t t);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Channel on non-final bytes is don't-care, so randomize it
    task automatic send_frame(input logic [2:0] ch);
        in_t t;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            t.rx_byte   = frame_bytes[i];
            t.frame_end = (i == frame_bytes.size() - 1);
            t.channel   = t.frame_end ? ch : 3'($urandom_range(0, 7));
            send_item(t);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_markers(input logic [7:0] st, input logic [7:0] md,
                               input logic [7:0] sp);
        write_reg(CFG_START_MARKER, st);
        write_reg(CFG_MIDDLE_MARKER, md);
        write_reg(CFG_STOP_MARKER, sp);
        cur_start  = st;
        cur_middle = md;
        cur_stop   = sp;
    endtask

    // Hold the input until every expected reading has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Well-formed long frame with random payload, then an optional fault
    function automatic void build_frame(input int unsigned len, input int unsigned total,
                                        input fault_t fault);
        logic [7:0]  csum;
        int unsigned cut;
        frame_bytes.delete();
        csum = '0;
        for (int unsigned p = 0; p < total; p++) frame_bytes.push_back(8'($urandom));
        frame_bytes[0] = cur_start;
        frame_bytes[1] = 8'(len);
        frame_bytes[2] = 8'(len);
        frame_bytes[3] = cur_middle;
        for (int unsigned p = SUM_START; p < SUM_START + len && p < total - 2; p++)
            csum += frame_bytes[p];
        frame_bytes[total - 2] = csum;
        frame_bytes[total - 1] = cur_stop;
        case (fault)
            FAULT_START:  frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
            FAULT_MIDDLE: frame_bytes[3] = frame_bytes[3] ^ 8'($urandom_range(1, 255));
            FAULT_STOP:   frame_bytes[total - 1] =
                              frame_bytes[total - 1] ^ 8'($urandom_range(1, 255));
            FAULT_SUM:    frame_bytes[total - 2] =
                              frame_bytes[total - 2] ^ 8'($urandom_range(1, 255));
            FAULT_TRUNC: begin
                cut = $urandom_range(1, total - 1);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
            default: ;
        endcase
    endfunction

    function automatic void build_noise(input int unsigned n);
        frame_bytes.delete();
        for (int unsigned p = 0; p < n; p++) frame_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1) frame_bytes[0] = cur_start;
    endfunction

    task automatic send_random_frame();
        int unsigned pick;
        int unsigned len;
        int unsigned extra;
        pick  = $urandom_range(0, 99);
        len   = $urandom_range(106, 118);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (pick < 55) begin
            if ($urandom_range(0, 9) == 0) len = 255;
            build_frame(len, len + 6 + extra, FAULT_NONE);
        end else if (pick < 80) begin
            build_frame(len, len + 6, fault_t'($urandom_range(FAULT_START, FAULT_TRUNC)));
        end else if (pick < 90) begin
            len = $urandom_range(0, 30);
            build_frame(len, len + 6, FAULT_NONE);
        end else begin
            build_noise($urandom_range(1, 30));
        end
        send_frame(3'($urandom_range(0, 7)));
    endtask

    task automatic run_random(input int unsigned n_frames);
        repeat (n_frames) send_random_frame();
    endtask

    initial begin
        board = new;
        board.reset_all();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames with reset markers
        frame_bytes = '{8'h68};                                  // single byte
        send_frame(3'd7);
        frame_bytes = '{8'h68, 8'h00, 8'h00};                    // no middle marker
        send_frame(3'd0);
        frame_bytes = '{8'h68, 8'h00, 8'h00, 8'h68, 8'h00, 8'h16}; // too short
        send_frame(3'd0);
        frame_bytes = '{8'h68, 8'h00, 8'h00, 8'h68, 8'h05, 8'h16}; // checksum off
        send_frame(3'd5);
        // length byte past the end: checksum and stop fall in the sum window
        frame_bytes = '{8'h68, 8'hFF, 8'hFF, 8'h68, 8'hEA, 8'h5A, 8'h16};
        send_frame(3'd2);
        run_random(PHASE_FRAMES);

        // Markers at zero/all-ones
        wait_drained();
        write_reg(CFG_UNUSED_INDEX, 8'($urandom));
        set_markers(8'h00, 8'hFF, 8'h00);
        run_random(PHASE_FRAMES);

        // Opposite extremes; long output hold while short frames pile up
        wait_drained();
        set_markers(8'hFF, 8'h00, 8'hFF);
        rx_hold = 1'b1;
        repeat (12) begin
            build_frame(0, 6, FAULT_NONE);
            send_frame(3'($urandom_range(0, 7)));
        end

        // Random markers, back-to-back traffic
        wait_drained();
        set_markers(8'($urandom), 8'($urandom), 8'($urandom));
        idle_on = 1'b0;
        run_random(PHASE_FRAMES);

        wait_drained();
        $display("Sent %0d bytes over four marker settings: %0d frames decoded, %0d rejected",
                 items_sent, board.frames_ok, board.frames_bad);
        $display("Checked %0d results, incl. input stalls from a full queue under a long hold",
                 board.results_checked);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== mbus_long_frame_meter_parser_unit.f =====
+incdir+hw/rtl
hw/rtl/mlfmp_pkg.sv
hw/rtl/mlfmp_front.sv
hw/rtl/mlfmp_queue.sv
hw/rtl/mlfmp_back.sv
hw/rtl/mbus_long_frame_meter_parser_unit.sv
tb/tb.sv
